// ----- rtl/rdsgd_pkg.sv -----
package rdsgd_pkg;

    // program service name store
    localparam int PS_DEPTH = 8;
    localparam int PS_AW    = $clog2(PS_DEPTH);

    // radio text store, kept as rows of four bytes
    localparam int RT_ROWS  = 16;
    localparam int RT_RW    = $clog2(RT_ROWS);

    // read index limits: program service first, radio text after it
    localparam logic [6:0] PS_LIMIT   = 7'd8;
    localparam logic [6:0] TEXT_LIMIT = 7'd72;

    // group types with text payload
    localparam logic [3:0] GROUP_PS = 4'd0;
    localparam logic [3:0] GROUP_RT = 4'd2;

    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef logic [RT_RW-1:0] rt_row_t;
    typedef logic [31:0]      rt_word_t;

    // one row write into the radio text store
    typedef struct packed {
        logic     en;
        rt_row_t  row;
        rt_word_t data;
    } rt_wr_t;

endpackage

// ----- rtl/rdsgd_text_store.sv -----
module rdsgd_text_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  rdsgd_pkg::rt_wr_t   wr,
    input  logic                rd_en,
    input  rdsgd_pkg::rt_row_t  rd_row,
    output rdsgd_pkg::rt_word_t rd_data
);

    rdsgd_pkg::rt_word_t                 mem [rdsgd_pkg::RT_ROWS];
    logic [rdsgd_pkg::RT_ROWS-1:0]       row_valid_reg;
    rdsgd_pkg::rt_word_t                 rd_data_reg;
    logic                                rd_valid_reg;

    // row storage, one row written per cycle
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.row] <= wr.data;
        end
    end

    // a row never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr.en) begin
            row_valid_reg[wr.row] <= 1'b1;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_row];
            rd_valid_reg <= row_valid_reg[rd_row];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/rds_group_decoder.sv -----
// RDS group decoder. Each request carries either one received RDS group to
// decode (tuser low) or a read of one stored text byte (tuser high). A group
// is decoded only while fm_active is set and the group has sync; it updates
// PI, PTY, TP, TA and the last group type, and group 0 / group 2 write two
// program-service or four radio-text bytes. Every request gives exactly one
// result, whose stored fields show the state after that request. One request
// is taken per clock while the result is not held; a result passes through
// an input register and a result stage that also holds the registered read
// of the radio-text row memory. Both text stores read as zero after reset:
// PS bytes by reset, radio-text rows by a per-row valid bit with no clearing pass.
module rds_group_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: fm_active
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] rds_sync, [16:1] block_a, [32:17] block_b, [48:33] block_c,
    // [64:49] block_d, [71:65] read_index
    input  logic [71:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] station_pi, [20:16] station_pty, [21] traffic_program,
    // [22] traffic_announce, [26:23] group_kind, [27] data_valid,
    // [35:28] read_byte, [39:36] zero
    output logic [39:0] m_tdata,
    // [0] accepted
    output logic        m_tuser
);

    // configuration
    logic fm_active_reg;

    // input stage
    logic        p1_valid_reg;
    logic        p1_op_reg;
    logic        p1_sync_reg;
    logic [15:0] p1_a_reg;
    logic [15:0] p1_b_reg;
    logic [15:0] p1_c_reg;
    logic [15:0] p1_d_reg;
    logic [6:0]  p1_idx_reg;

    // decoder state
    logic [7:0]  ps_reg [rdsgd_pkg::PS_DEPTH];
    logic [15:0] pi_reg;
    logic [4:0]  pty_reg;
    logic [1:0]  tp_ta_reg;
    logic [3:0]  last_group_reg;
    logic        seen_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_accepted_reg;
    logic        out_text_sel_reg;
    logic [1:0]  out_byte_sel_reg;
    logic [7:0]  out_ps_byte_reg;

    logic        advance;
    logic        is_read;
    logic        group_ok;
    logic        decode_ok;
    logic [3:0]  kind;
    logic [6:0]  text_off;
    logic        is_ps;
    logic        is_rt;
    logic        out_accepted_next;
    logic        out_text_sel_next;
    logic [7:0]  out_ps_byte_next;
    logic [7:0]  text_byte;
    logic [7:0]  read_byte;

    rdsgd_pkg::rt_wr_t   rt_wr;
    rdsgd_pkg::rt_word_t rt_rd_data;

    // handshake: input stage moves on when the result slot is free or emptying
    assign advance  = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fm_active_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            fm_active_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            p1_op_reg   <= s_tuser;
            p1_sync_reg <= s_tdata[0];
            p1_a_reg    <= s_tdata[16:1];
            p1_b_reg    <= s_tdata[32:17];
            p1_c_reg    <= s_tdata[48:33];
            p1_d_reg    <= s_tdata[64:49];
            p1_idx_reg  <= s_tdata[71:65];
        end
    end

    // request decode
    assign is_read   = (rdsgd_pkg::op_t'(p1_op_reg) == rdsgd_pkg::OP_READ);
    assign group_ok  = !is_read && fm_active_reg && p1_sync_reg;
    assign decode_ok = advance && group_ok;
    assign kind      = p1_b_reg[15:12];
    assign text_off  = p1_idx_reg - rdsgd_pkg::PS_LIMIT;
    assign is_ps     = (p1_idx_reg < rdsgd_pkg::PS_LIMIT);
    assign is_rt     = !is_ps && (p1_idx_reg < rdsgd_pkg::TEXT_LIMIT);

    // header fields of an accepted group
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pi_reg         <= '0;
            pty_reg        <= '0;
            tp_ta_reg      <= '0;
            last_group_reg <= '0;
            seen_reg       <= 1'b0;
        end else if (decode_ok) begin
            pi_reg         <= p1_a_reg;
            pty_reg        <= p1_b_reg[9:5];
            tp_ta_reg      <= {p1_b_reg[10], p1_b_reg[4]};
            last_group_reg <= kind;
            seen_reg       <= 1'b1;
        end
    end

    // program service bytes, two per group 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg <= '{default: 8'h00};
        end else if (decode_ok && kind == rdsgd_pkg::GROUP_PS) begin
            ps_reg[{p1_b_reg[1:0], 1'b0}] <= p1_d_reg[15:8];
            ps_reg[{p1_b_reg[1:0], 1'b1}] <= p1_d_reg[7:0];
        end
    end

    // radio text row write, lowest byte lands at the lowest address
    always_comb begin
        rt_wr.en   = decode_ok && (kind == rdsgd_pkg::GROUP_RT);
        rt_wr.row  = p1_b_reg[rdsgd_pkg::RT_RW-1:0];
        rt_wr.data = {p1_d_reg[7:0], p1_d_reg[15:8], p1_c_reg[7:0], p1_c_reg[15:8]};
    end

    rdsgd_text_store u_text_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (rt_wr),
        .rd_en   (advance && is_read && is_rt),
        .rd_row  (text_off[5:2]),
        .rd_data (rt_rd_data)
    );

    // result stage contents
    always_comb begin
        out_accepted_next = group_ok;
        out_text_sel_next = is_read && is_rt;
        out_ps_byte_next  = (is_read && is_ps) ? ps_reg[p1_idx_reg[rdsgd_pkg::PS_AW-1:0]]
                                               : 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_accepted_reg <= out_accepted_next;
            out_text_sel_reg <= out_text_sel_next;
            out_byte_sel_reg <= text_off[1:0];
            out_ps_byte_reg  <= out_ps_byte_next;
        end
    end

    // byte select from the registered text row
    always_comb begin
        unique case (out_byte_sel_reg)
            2'd0:    text_byte = rt_rd_data[7:0];
            2'd1:    text_byte = rt_rd_data[15:8];
            2'd2:    text_byte = rt_rd_data[23:16];
            default: text_byte = rt_rd_data[31:24];
        endcase
        read_byte = out_text_sel_reg ? text_byte : out_ps_byte_reg;
    end

    // stored fields are shown live: they only change when the result moves on
    assign m_tdata = {4'b0000, read_byte, seen_reg, last_group_reg,
                      tp_ta_reg[0], tp_ta_reg[1], pty_reg, pi_reg};
    assign m_tuser = out_accepted_reg;

    // an accepted group always leaves the valid flag set
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_accepted_reg |-> seen_reg)
        else $error("accepted result without data_valid");

    // input side only stalls when both stages are full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> p1_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    // a decode request never returns radio text
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_accepted_reg |-> !out_text_sel_reg)
        else $error("decode result selects a text byte");

    // a pending request keeps its stored state while the result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> $stable(pi_reg) && $stable(seen_reg))
        else $error("state changed under a held result");

endmodule
